>>> rtl/msfd_pkg.sv
// Shared types, constants and helper functions for the motor stall detector.
// No dependencies; the top level and the checker import this package.
`default_nettype none

package msfd_pkg;

  localparam int MOTORS   = 4;
  localparam int LOOP_HZ  = 1000;
  localparam int MS_PER_S = 1000;

  localparam int MOTOR_W  = 2;
  localparam int MOTOR_AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int SPEED_W  = 20;
  localparam int DRIVE_W  = 16;
  localparam int CUR_W    = 16;
  localparam int DUR_W    = 14;
  localparam int PWM_W    = 15;
  localparam int TICK_W   = 17;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic [TICK_W-1:0]  TICKS_MAX    = {TICK_W{1'b1}};
  localparam logic [SPEED_W-1:0] TARGET_MIN   = SPEED_W'(80);  // 5 rpm in 1/16 rpm
  localparam logic [SPEED_W-1:0] MEASURED_MAX = SPEED_W'(32);  // 2 rpm in 1/16 rpm

  localparam logic [DUR_W-1:0] DUR_RESET    = DUR_W'(500);
  localparam logic [CUR_W-1:0] OC_RESET     = CUR_W'(10000);
  localparam logic [PWM_W-1:0] PWM_MIN_RESET = PWM_W'(3277);

  // ms -> ticks: floor(dur * LOOP_HZ / 1000) as a multiply by a rounded-up
  // reciprocal. Exact for any 14-bit duration since 2^-11 < 1/1000.
  localparam int          SCALE_SHIFT = 25;
  localparam int          SCALE_W     = 30;
  localparam logic [63:0] SCALE_MULT  =
      ((64'(LOOP_HZ) << SCALE_SHIFT) + 64'(MS_PER_S - 1)) / 64'(MS_PER_S);
  localparam int          PROD_W      = DUR_W + SCALE_W;
  localparam int          QUOT_W      = PROD_W - SCALE_SHIFT;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_STALL_DURATION = 2'd0,
    CFG_OC_LIMIT       = 2'd1,
    CFG_PWM_MIN        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                        operation;
    logic [MOTOR_W-1:0]         motor;
    logic                       motor_enabled;
    logic signed [SPEED_W-1:0]  target_speed;
    logic signed [SPEED_W-1:0]  measured_speed;
    logic signed [DRIVE_W-1:0]  drive_level;
    logic                       current_ok;
    logic [CUR_W-1:0]           current_ma;
  } sample_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor_out;
    logic               stalled_flag;
    logic               overcurrent_flag;
    logic               disable_request;
    logic [TICK_W-1:0]  stall_count;
  } result_t;

  // Per-motor state word kept in RAM
  typedef struct packed {
    logic              stall_latch;
    logic              oc_latch;
    logic [TICK_W-1:0] ticks;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [SPEED_W-1:0] mag_speed(logic signed [SPEED_W-1:0] v);
    return v[SPEED_W-1] ? (~SPEED_W'(v) + SPEED_W'(1)) : SPEED_W'(v);
  endfunction

  function automatic logic [DRIVE_W-1:0] mag_drive(logic signed [DRIVE_W-1:0] v);
    return v[DRIVE_W-1] ? (~DRIVE_W'(v) + DRIVE_W'(1)) : DRIVE_W'(v);
  endfunction

  function automatic logic [TICK_W-1:0] ticks_of(logic [DUR_W-1:0] dur);
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    prod = PROD_W'(dur) * PROD_W'(SCALE_MULT[SCALE_W-1:0]);
    quot = prod[PROD_W-1:SCALE_SHIFT];
    return (quot > QUOT_W'(TICKS_MAX)) ? TICKS_MAX : quot[TICK_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/msfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/motor_stall_fault_detector_top.sv
// Pipeline: an accepted sample word is captured in stage 1 while its RAM
//   read is registered; it is updated and loaded into the result register
//   once that register is free, which raises result_valid.
// Throughput: one sample word per cycle unless result is stalled; per-motor
//   state is in a 1-read 1-write RAM, forwarding a write on the read edge.
// Reset (rst, synchronous): per-motor valid bits clear, so every motor reads
//   as zero state at once; config registers return to their defaults.
`default_nettype none

module motor_stall_fault_detector_top
  import msfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // sample channel
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire sample_t           sample,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result,
  // config write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  // ---------------------------------------------------------------------
  // Config registers. Duration is kept as a tick threshold, converted on
  // the write so it is ready for the very next sample.
  // ---------------------------------------------------------------------
  logic [TICK_W-1:0] thresh;
  logic [CUR_W-1:0]  oc_limit;
  logic [PWM_W-1:0]  pwm_min;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh   <= ticks_of(DUR_RESET);
      oc_limit <= OC_RESET;
      pwm_min  <= PWM_MIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STALL_DURATION: thresh   <= ticks_of(cfg_data[DUR_W-1:0]);
        CFG_OC_LIMIT:       oc_limit <= cfg_data[CUR_W-1:0];
        CFG_PWM_MIN:        pwm_min  <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the word whose RAM read is in flight;
  // it moves into the output register when that register is free.
  // ---------------------------------------------------------------------
  logic    s1_valid;
  sample_t s1;
  logic    out_free;
  logic    s1_adv;
  logic    accept;

  assign out_free     = !result_valid || !result_stall;
  assign s1_adv       = s1_valid && out_free;
  assign sample_stall = s1_valid && !out_free;
  assign accept       = sample_valid && !sample_stall;

  logic [MOTOR_AW-1:0] rd_addr;
  logic [MOTOR_AW-1:0] s1_addr;
  logic                s1_in_range;
  assign rd_addr     = MOTOR_AW'(sample.motor);
  assign s1_addr     = MOTOR_AW'(s1.motor);
  assign s1_in_range = (32'(s1.motor) < MOTORS);

  // ---------------------------------------------------------------------
  // State RAM plus valid bits (clear and reset just drop the valid bits)
  // ---------------------------------------------------------------------
  logic [ENTRY_W-1:0] ram_rdata;
  logic               wr_req;     // stage 1 word updates its entry
  logic               wr_en;
  entry_t             upd;
  logic [MOTORS-1:0]  ent_valid;

  assign wr_en = s1_adv && wr_req;

  msfd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MOTORS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (upd),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  logic clear_now;
  assign clear_now = s1_adv && (s1.operation == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (clear_now) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[s1_addr] <= 1'b1;
    end
  end

  // Forwarding: the read for a new word may coincide with the write of the
  // word ahead of it to the same motor; capture that written entry.
  logic   fwd_hit;
  entry_t fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= wr_en && (s1_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
        fwd_hit  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= sample;
      fwd_data <= upd;
    end
  end

  // ---------------------------------------------------------------------
  // Update of one motor's state
  // ---------------------------------------------------------------------
  entry_t             cur;
  result_t            res;
  logic [SPEED_W-1:0] tgt_mag;
  logic [SPEED_W-1:0] meas_mag;
  logic [DRIVE_W-1:0] pwm_mag;
  logic               driving;

  assign tgt_mag  = mag_speed(s1.target_speed);
  assign meas_mag = mag_speed(s1.measured_speed);
  assign pwm_mag  = mag_drive(s1.drive_level);

  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (ent_valid[s1_addr]) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end

    upd     = cur;
    res     = '0;
    wr_req  = 1'b0;
    driving = 1'b0;

    case (s1.operation)
      OP_CLEAR: ;  // all-zero result; valid bits drop on advance
      OP_SAMPLE: begin
        res.motor_out = s1.motor;
        if (s1_in_range) begin
          wr_req = 1'b1;
          if (!s1.motor_enabled) begin
            upd.ticks = '0;
          end else begin
            if (s1.current_ok && (s1.current_ma > oc_limit)) begin
              upd.oc_latch = 1'b1;
            end
            driving = (tgt_mag > TARGET_MIN) &&
                      ((pwm_mag > DRIVE_W'(pwm_min)) || upd.oc_latch) &&
                      (meas_mag < MEASURED_MAX);
            if (driving) begin
              if (cur.ticks < thresh) begin
                upd.ticks = cur.ticks + TICK_W'(1);
              end
            end else begin
              upd.ticks = '0;
            end
            // zero threshold stalls on any enabled sample
            if (upd.ticks >= thresh) begin
              upd.stall_latch     = 1'b1;
              res.disable_request = 1'b1;
            end
          end
          res.stalled_flag     = upd.stall_latch;
          res.overcurrent_flag = upd.oc_latch;
          res.stall_count      = upd.ticks;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/msfd_checker.sv
// Port-level assertions for the motor stall detector, bound to the top level.
// Depends on msfd_pkg for the word types.
`default_nettype none

module msfd_checker
  import msfd_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    sample_valid,
  input wire logic    sample_stall,
  input wire sample_t sample,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // Back-pressure on samples only comes from a full, stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample stalled without a stalled result");

  // An accepted sample reaches result_valid when the output drains.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ((sample_valid && !sample_stall) ##1 !result_stall) |=> result_valid)
    else $error("accepted sample produced no result in time");

  // A disable request always comes with the stall latch set.
  a_disable_latched: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.disable_request) |-> result.stalled_flag)
    else $error("disable request without stall flag");

  // Held result word stays put while stalled.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind motor_stall_fault_detector_top msfd_checker u_msfd_checker (.*);

`default_nettype wire
